// ===== rtl/lgrs_pkg.sv =====
// Package for the Life generation row step unit.
// Holds the board geometry constants and the shared types and functions.
// No dependencies.
`default_nettype none

package lgrs_pkg;

    localparam int MAX_WIDTH = 64;
    localparam int COLS      = 64;
    localparam int WIDTH_W   = 7;
    localparam int COUNT_W   = 4;

    localparam logic [WIDTH_W-1:0] WIDTH_RESET = WIDTH_W'(MAX_WIDTH);
    localparam logic [COUNT_W-1:0] BIRTH_COUNT = COUNT_W'(3);
    localparam logic [COUNT_W-1:0] STAY_COUNT  = COUNT_W'(2);

    typedef logic [COLS-1:0] row_t;

    typedef struct packed {
        row_t up;
        row_t mid;
        row_t down;
        logic row_last;
    } job_t;

    typedef struct packed {
        logic valid;
        logic both;
    } win_stat_t;

    function automatic row_t width_mask(input logic [WIDTH_W-1:0] width);
        int   w;
        row_t m;
        w = int'(width);
        if (w > MAX_WIDTH) begin
            w = MAX_WIDTH;
        end
        for (int c = 0; c < COLS; c++) begin
            m[c] = (c < w);
        end
        return m;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/lgrs_row_window.sv =====
// Row window: keeps the two previous rows and the job register of pending results.
// A last row after another leaves two results to issue, one per unstalled cycle.
// Depends on lgrs_pkg.
`default_nettype none

module lgrs_row_window (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire lgrs_pkg::row_t    in_row,
    input  wire logic              in_last,
    input  wire lgrs_pkg::row_t    mask,
    input  wire logic              issue,
    output lgrs_pkg::job_t         job,
    output lgrs_pkg::win_stat_t    stat
);
    import lgrs_pkg::*;

    row_t row_above_reg, row_above_next;
    row_t row_center_reg, row_center_next;
    logic have_center_reg, have_center_next;
    row_t up_reg, up_next;
    row_t mid_reg, mid_next;
    row_t down_reg, down_next;
    logic pend_first_reg, pend_first_next;
    logic pend_last_reg, pend_last_next;
    row_t row_in;
    logic accept;

    assign row_in   = in_row & mask;
    assign in_ready = !(pend_first_reg || pend_last_reg)
                      || (issue && !(pend_first_reg && pend_last_reg));
    assign accept   = in_valid && in_ready;

    always_comb begin
        row_above_next   = row_above_reg;
        row_center_next  = row_center_reg;
        have_center_next = have_center_reg;
        up_next          = up_reg;
        mid_next         = mid_reg;
        down_next        = down_reg;
        pend_first_next  = pend_first_reg;
        pend_last_next   = pend_last_reg;

        if (issue) begin
            if (pend_first_reg && pend_last_reg) begin
                up_next         = mid_reg;
                mid_next        = down_reg;
                down_next       = '0;
                pend_first_next = 1'b0;
            end else begin
                pend_first_next = 1'b0;
                pend_last_next  = 1'b0;
            end
        end

        if (accept) begin
            if (have_center_reg) begin
                up_next         = row_above_reg;
                mid_next        = row_center_reg;
                down_next       = row_in;
                pend_first_next = 1'b1;
            end else begin
                up_next         = '0;
                mid_next        = row_in;
                down_next       = '0;
                pend_first_next = 1'b0;
            end
            pend_last_next = in_last;

            if (in_last) begin
                row_above_next   = '0;
                row_center_next  = '0;
                have_center_next = 1'b0;
            end else begin
                row_above_next   = have_center_reg ? row_center_reg : '0;
                row_center_next  = row_in;
                have_center_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_above_reg   <= '0;
            row_center_reg  <= '0;
            have_center_reg <= 1'b0;
            pend_first_reg  <= 1'b0;
            pend_last_reg   <= 1'b0;
        end else begin
            row_above_reg   <= row_above_next;
            row_center_reg  <= row_center_next;
            have_center_reg <= have_center_next;
            pend_first_reg  <= pend_first_next;
            pend_last_reg   <= pend_last_next;
        end
    end

    always_ff @(posedge aclk) begin
        up_reg   <= up_next;
        mid_reg  <= mid_next;
        down_reg <= down_next;
    end

    assign job.up       = up_reg;
    assign job.mid      = mid_reg;
    assign job.down     = down_reg;
    assign job.row_last = !pend_first_reg;
    assign stat.valid   = pend_first_reg || pend_last_reg;
    assign stat.both    = pend_first_reg && pend_last_reg;

endmodule

`default_nettype wire

// ===== rtl/lgrs_cell_rule.sv =====
// Cell rule: next generation of the middle row from three rows, born on 3, survives on 2 or 3.
// Cells beyond the row ends count as dead; the result is masked to the board width.
// Depends on lgrs_pkg.
`default_nettype none

module lgrs_cell_rule (
    input  wire lgrs_pkg::row_t up,
    input  wire lgrs_pkg::row_t mid,
    input  wire lgrs_pkg::row_t down,
    input  wire lgrs_pkg::row_t mask,
    output lgrs_pkg::row_t      next_row
);
    import lgrs_pkg::*;

    row_t up_l, up_r, mid_l, mid_r, down_l, down_r;
    row_t alive;

    // Bit c of a left copy holds column c-1, of a right copy column c+1.
    assign up_l   = {up[COLS-2:0], 1'b0};
    assign up_r   = {1'b0, up[COLS-1:1]};
    assign mid_l  = {mid[COLS-2:0], 1'b0};
    assign mid_r  = {1'b0, mid[COLS-1:1]};
    assign down_l = {down[COLS-2:0], 1'b0};
    assign down_r = {1'b0, down[COLS-1:1]};

    always_comb begin
        logic [COUNT_W-1:0] n;
        for (int c = 0; c < COLS; c++) begin
            n = COUNT_W'(up_l[c]) + COUNT_W'(up[c]) + COUNT_W'(up_r[c])
              + COUNT_W'(mid_l[c]) + COUNT_W'(mid_r[c])
              + COUNT_W'(down_l[c]) + COUNT_W'(down[c]) + COUNT_W'(down_r[c]);
            alive[c] = (n == BIRTH_COUNT) || (mid[c] && (n == STAY_COUNT));
        end
    end

    assign next_row = alive & mask;

endmodule

`default_nettype wire

// ===== rtl/life_generation_row_step_unit.sv =====
// Top level of the Life generation row step unit.
// Instantiates lgrs_row_window and lgrs_cell_rule and holds the width and output registers.
// Depends on lgrs_pkg, lgrs_row_window and lgrs_cell_rule.
`default_nettype none

// The board streams in one row per beat, bit c of s_tdata being column c, with s_tlast on the
// final row. Each row after the first yields one beat with the next generation of the row
// before it; the final row yields one more beat, its own successor, with m_tlast high. Rows
// are taken one per cycle while the output is not stalled; a row marked last holds the input
// while two results are pending, as they leave through the single output register one per
// cycle while not stalled. A result passes through the job register and then the output
// register; the successor of the final row of a multi-row board follows as the next beat.
// Columns at or beyond board_width (cfg_data) are dead; write it only while the unit is idle.
module life_generation_row_step_unit (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [lgrs_pkg::COLS-1:0]       s_tdata,  // row_cells
    input  wire logic                            s_tlast,  // last_row
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [lgrs_pkg::COLS-1:0]            m_tdata,  // next_row
    output logic                                 m_tlast,  // row_last
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [lgrs_pkg::WIDTH_W-1:0]    cfg_data  // board_width
);
    import lgrs_pkg::*;

    logic [WIDTH_W-1:0] width_reg;
    row_t               mask;
    job_t               job;
    win_stat_t          stat;
    row_t               gen_row;
    logic               issue;
    logic               m_tvalid_reg, m_tvalid_next;
    row_t               m_tdata_reg;
    logic               m_tlast_reg;

    assign cfg_ready = 1'b1;
    assign mask      = width_mask(width_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg <= WIDTH_RESET;
        end else if (cfg_valid) begin
            width_reg <= cfg_data;
        end
    end

    lgrs_row_window u_window (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_row   (s_tdata),
        .in_last  (s_tlast),
        .mask     (mask),
        .issue    (issue),
        .job      (job),
        .stat     (stat)
    );

    lgrs_cell_rule u_rule (
        .up       (job.up),
        .mid      (job.mid),
        .down     (job.down),
        .mask     (mask),
        .next_row (gen_row)
    );

    assign issue = stat.valid && (!m_tvalid_reg || m_tready);

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (issue) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            m_tdata_reg <= gen_row;
            m_tlast_reg <= job.row_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    a_hold_on_two_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.both |-> !s_tready)
        else $error("input taken while two results are pending");

    a_issue_fills_output: assert property (@(posedge aclk) disable iff (!aresetn)
        issue |=> m_tvalid)
        else $error("issued result did not reach the output register");

    a_result_masked: assert property (@(posedge aclk) disable iff (!aresetn)
        issue |=> ((m_tdata & ~$past(mask)) == '0))
        else $error("result has live cells beyond the board width");

endmodule

`default_nettype wire
